// ----- rtl/core/rgb2hsv_pkg.sv -----
`timescale 1ns / 1ps

package rgb2hsv_pkg;

    // channel width and divider geometry
    localparam int CHAN_W    = 16;
    localparam int HDEN_W    = 19;          // holds 6 * (max - min)
    localparam int DIV_STEPS = CHAN_W;      // one quotient bit per stage
    localparam int FRONT_STAGES = 3;
    localparam int LATENCY   = FRONT_STAGES + DIV_STEPS;

    // hue sector codes
    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } t_rgb_in;

    typedef struct packed {
        logic [CHAN_W-1:0] hue_out;
        logic [CHAN_W-1:0] saturation_out;
        logic [CHAN_W-1:0] value_out;
    } t_hsv_out;

    // state of both dividers between two pipeline stages
    typedef struct packed {
        logic [HDEN_W-1:0] hue_rem;
        logic [HDEN_W-1:0] hue_den;
        logic [CHAN_W-1:0] hue_quo;
        logic [CHAN_W-1:0] sat_rem;
        logic [CHAN_W-1:0] sat_shift;
        logic [CHAN_W-1:0] sat_quo;
        logic [CHAN_W-1:0] vmax;
        logic              zero;
    } t_div_data;

endpackage

// ----- rtl/core/rgb2hsv_front.sv -----
`timescale 1ns / 1ps

module rgb2hsv_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  rgb2hsv_pkg::t_rgb_in  i_pixel,
    output logic                  o_valid,
    output rgb2hsv_pkg::t_div_data o_div
);
    import rgb2hsv_pkg::*;

    // stage 1 registers: channels, extremes, sector
    logic              r_s1_valid;
    logic [CHAN_W-1:0] r_s1_red, r_s1_green, r_s1_blue, r_s1_max, r_s1_min;
    logic [1:0]        r_s1_sect;
    logic [CHAN_W-1:0] n_s1_max, n_s1_min;
    logic [1:0]        n_s1_sect;

    // stage 2 registers: spread and signed channel difference
    logic              r_s2_valid;
    logic [CHAN_W-1:0] r_s2_delta, r_s2_max;
    logic [CHAN_W:0]   r_s2_diff;
    logic [1:0]        r_s2_sect;
    logic [CHAN_W:0]   n_s2_diff;

    // stage 3 registers: divider operands
    logic              r_s3_valid;
    t_div_data         r_s3_div;
    t_div_data         n_s3_div;
    logic [HDEN_W-1:0] w_d2, w_d4, w_d6, w_add;
    logic [HDEN_W:0]   w_num;

    // max, min and sector with ties going red, then green
    always_comb begin
        if (i_pixel.red_in >= i_pixel.green_in && i_pixel.red_in >= i_pixel.blue_in) begin
            n_s1_sect = SECT_RED;
            n_s1_max  = i_pixel.red_in;
        end else if (i_pixel.green_in >= i_pixel.blue_in) begin
            n_s1_sect = SECT_GREEN;
            n_s1_max  = i_pixel.green_in;
        end else begin
            n_s1_sect = SECT_BLUE;
            n_s1_max  = i_pixel.blue_in;
        end
        if (i_pixel.red_in <= i_pixel.green_in) begin
            n_s1_min = (i_pixel.red_in <= i_pixel.blue_in) ? i_pixel.red_in : i_pixel.blue_in;
        end else begin
            n_s1_min = (i_pixel.green_in <= i_pixel.blue_in) ? i_pixel.green_in
                                                             : i_pixel.blue_in;
        end
    end

    // difference of the two non-leading channels
    always_comb begin
        case (r_s1_sect)
            SECT_RED:   n_s2_diff = {1'b0, r_s1_green} - {1'b0, r_s1_blue};
            SECT_GREEN: n_s2_diff = {1'b0, r_s1_blue} - {1'b0, r_s1_red};
            default:    n_s2_diff = {1'b0, r_s1_red} - {1'b0, r_s1_green};
        endcase
    end

    // hue numerator with sector offset and wrap, saturation dividend split
    assign w_d2 = HDEN_W'({r_s2_delta, 1'b0});
    assign w_d4 = HDEN_W'({r_s2_delta, 2'b00});
    assign w_d6 = w_d2 + w_d4;

    always_comb begin
        case (r_s2_sect)
            SECT_RED:   w_add = r_s2_diff[CHAN_W] ? w_d6 : '0;
            SECT_GREEN: w_add = w_d2;
            default:    w_add = w_d4;
        endcase
        w_num = {{(HDEN_W - CHAN_W){r_s2_diff[CHAN_W]}}, r_s2_diff} + {1'b0, w_add};

        n_s3_div.hue_rem   = w_num[HDEN_W-1:0];
        n_s3_div.hue_den   = w_d6;
        n_s3_div.hue_quo   = '0;
        // delta * 65535 = (delta << 16) - delta, split into high and low halves
        n_s3_div.sat_rem   = r_s2_delta - CHAN_W'(r_s2_delta != '0);
        n_s3_div.sat_shift = CHAN_W'(-r_s2_delta);
        n_s3_div.sat_quo   = '0;
        n_s3_div.vmax      = r_s2_max;
        n_s3_div.zero      = (r_s2_delta == '0);
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_s1_red   <= i_pixel.red_in;
        r_s1_green <= i_pixel.green_in;
        r_s1_blue  <= i_pixel.blue_in;
        r_s1_max   <= n_s1_max;
        r_s1_min   <= n_s1_min;
        r_s1_sect  <= n_s1_sect;
        r_s2_delta <= r_s1_max - r_s1_min;
        r_s2_max   <= r_s1_max;
        r_s2_diff  <= n_s2_diff;
        r_s2_sect  <= r_s1_sect;
        r_s3_div   <= n_s3_div;
    end

    assign o_valid = r_s3_valid;
    assign o_div   = r_s3_div;

endmodule

// ----- rtl/core/rgb2hsv_div_step.sv -----
`timescale 1ns / 1ps

module rgb2hsv_div_step (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  rgb2hsv_pkg::t_div_data i_data,
    output logic                   o_valid,
    output rgb2hsv_pkg::t_div_data o_data
);
    import rgb2hsv_pkg::*;

    logic              r_valid;
    t_div_data         r_data;
    t_div_data         n_data;
    logic [HDEN_W:0]   w_hue_sh;
    logic              w_hue_ge;
    logic [CHAN_W:0]   w_sat_sh;
    logic              w_sat_ge;

    // one restoring step for hue and for saturation
    always_comb begin
        w_hue_sh = {i_data.hue_rem, 1'b0};
        w_hue_ge = (w_hue_sh >= {1'b0, i_data.hue_den});
        w_sat_sh = {i_data.sat_rem, i_data.sat_shift[CHAN_W-1]};
        w_sat_ge = (w_sat_sh >= {1'b0, i_data.vmax});

        n_data           = i_data;
        n_data.hue_rem   = w_hue_ge ? HDEN_W'(w_hue_sh - {1'b0, i_data.hue_den})
                                    : w_hue_sh[HDEN_W-1:0];
        n_data.hue_quo   = {i_data.hue_quo[CHAN_W-2:0], w_hue_ge};
        n_data.sat_rem   = w_sat_ge ? CHAN_W'(w_sat_sh - {1'b0, i_data.vmax})
                                    : w_sat_sh[CHAN_W-1:0];
        n_data.sat_shift = {i_data.sat_shift[CHAN_W-2:0], 1'b0};
        n_data.sat_quo   = {i_data.sat_quo[CHAN_W-2:0], w_sat_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/core/rgb_to_hsv_converter.sv -----
`timescale 1ns / 1ps
// RGB to HSV converter, 16 bits per channel.
// Input: a pixel on i_pixel is transferred at each rising edge where start is
// high and busy is low. busy is always low, so a pixel may be offered in
// every cycle and the block sustains one pixel per clock.
// Output: each result sits on o_hsv for exactly one cycle, flagged by o_done;
// the receiver has no way to hold it off, and results come out in the order
// pixels went in.
// Three front stages find max, min, sector and the divider operands; then
// 16 stages of a pipelined restoring divider produce one bit each of hue
// and saturation quotient, and the result leaves the last divider stage.
// Black and grey pixels give hue and saturation of zero.
// Reset (i_rst_n low, synchronous) clears all stage valid bits; pixels in
// flight are dropped and o_done stays low until new pixels arrive.
module rgb_to_hsv_converter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rgb2hsv_pkg::t_rgb_in  i_pixel,
    output logic                  o_done,
    output rgb2hsv_pkg::t_hsv_out o_hsv
);
    import rgb2hsv_pkg::*;

    logic [DIV_STEPS:0] w_valid;
    t_div_data          w_data [0:DIV_STEPS];
    t_div_data          w_last;

    // pipeline never stalls
    assign busy = 1'b0;

    // front stages
    rgb2hsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_pixel (i_pixel),
        .o_valid (w_valid[0]),
        .o_div   (w_data[0])
    );

    // divider stages, one quotient bit each
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        rgb2hsv_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    // result fields, zero hue and saturation for grey pixels
    assign w_last               = w_data[DIV_STEPS];
    assign o_done               = w_valid[DIV_STEPS];
    assign o_hsv.hue_out        = w_last.zero ? '0 : w_last.hue_quo;
    assign o_hsv.saturation_out = w_last.zero ? '0 : w_last.sat_quo;
    assign o_hsv.value_out      = w_last.vmax;

    // checks
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LATENCY))
        else $error("result without a matching transfer");

    a_grey_hue_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_hsv.saturation_out == '0 |-> o_hsv.hue_out == '0)
        else $error("nonzero hue with zero saturation");

    a_black_sat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_hsv.value_out == '0 |-> o_hsv.saturation_out == '0)
        else $error("nonzero saturation for black pixel");

endmodule

// ----- sim/rgb_to_hsv_converter_test.sv -----
`timescale 1ns / 1ps

module rgb_to_hsv_converter_test;

    import rgb2hsv_pkg::*;

    localparam int NUM_RANDOM  = 1380;
    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_SHOWN   = 10;

    // one row of the directed table: expected result typed in only when known is set
    typedef struct packed {
        t_rgb_in  px;
        logic     known;
        t_hsv_out hsv;
    } t_pixel_case;

    localparam int NUM_DIRECTED = 22;
    localparam t_pixel_case DIRECTED_CASES [NUM_DIRECTED] = '{
        // black, white, grey and saturated red read straight off the definition
        '{'{16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
        '{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{16'h0000, 16'h0000, 16'hFFFF}},
        '{'{16'h8000, 16'h8000, 16'h8000}, 1'b1, '{16'h0000, 16'h0000, 16'h8000}},
        '{'{16'h0001, 16'h0001, 16'h0001}, 1'b1, '{16'h0000, 16'h0000, 16'h0001}},
        '{'{16'hFFFF, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 16'hFFFF, 16'hFFFF}},
        '{'{16'h0001, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 16'hFFFF, 16'h0001}},
        // pure primaries and secondaries, ties between maxima
        '{'{16'h0000, 16'hFFFF, 16'h0000}, 1'b0, '0},
        '{'{16'h0000, 16'h0000, 16'hFFFF}, 1'b0, '0},
        '{'{16'hFFFF, 16'hFFFF, 16'h0000}, 1'b0, '0},
        '{'{16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, '0},
        '{'{16'h0000, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{16'h0001, 16'h0000, 16'h0001}, 1'b0, '0},
        '{'{16'h0000, 16'h0001, 16'h0001}, 1'b0, '0},
        // red maximum with green below blue wraps around
        '{'{16'hFFFF, 16'h0000, 16'h0001}, 1'b0, '0},
        '{'{16'hFFFF, 16'h0000, 16'hFFFE}, 1'b0, '0},
        // tiny spread between max and min
        '{'{16'hFFFF, 16'hFFFE, 16'hFFFE}, 1'b0, '0},
        '{'{16'h0002, 16'h0001, 16'h0001}, 1'b0, '0},
        // assorted sectors and bit patterns
        '{'{16'hFFFF, 16'h8000, 16'h0000}, 1'b0, '0},
        '{'{16'h8000, 16'h4000, 16'h2000}, 1'b0, '0},
        '{'{16'h1234, 16'hABCD, 16'h5678}, 1'b0, '0},
        '{'{16'hAAAA, 16'h5555, 16'hFFFF}, 1'b0, '0},
        '{'{16'h5555, 16'hAAAA, 16'h0000}, 1'b0, '0}
    };

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_rgb_in  i_pixel;
    logic     o_done;
    t_hsv_out o_hsv;

    // expectation that travels with the pixel on the bus
    logic     pix_known;
    t_hsv_out pix_hsv;

    t_hsv_out hsv_expected [$];
    int       mismatch_count;
    int       cycle_count;
    bit       burst_mode;

    rgb_to_hsv_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_pixel (i_pixel),
        .o_done  (o_done),
        .o_hsv   (o_hsv)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // exact integer hexcone conversion
    function automatic t_hsv_out hsv_of(input t_rgb_in px);
        t_hsv_out          res;
        logic [CHAN_W-1:0] vmax;
        logic [CHAN_W-1:0] vmin;
        logic [1:0]        sector;
        longint            delta;
        longint            num;
        longint            sat;
        longint            hue;
        vmax = px.red_in;
        if (px.green_in > vmax) vmax = px.green_in;
        if (px.blue_in > vmax) vmax = px.blue_in;
        vmin = px.red_in;
        if (px.green_in < vmin) vmin = px.green_in;
        if (px.blue_in < vmin) vmin = px.blue_in;
        delta = longint'(vmax) - longint'(vmin);
        sat = (vmax == '0) ? 0 : (delta * 65535) / longint'(vmax);
        // red wins ties, then green
        if (px.red_in == vmax) begin
            sector = SECT_RED;
        end else if (px.green_in == vmax) begin
            sector = SECT_GREEN;
        end else begin
            sector = SECT_BLUE;
        end
        hue = 0;
        num = 0;
        if (sat != 0 && delta != 0) begin
            case (sector)
                SECT_RED: begin
                    num = longint'(px.green_in) - longint'(px.blue_in);
                end
                SECT_GREEN: begin
                    num = longint'(px.blue_in) - longint'(px.red_in) + 2 * delta;
                end
                default: begin
                    num = longint'(px.red_in) - longint'(px.green_in) + 4 * delta;
                end
            endcase
            if (num < 0) num = num + 6 * delta;
            hue = (num * 65536) / (6 * delta);
        end
        res.hue_out        = hue[CHAN_W-1:0];
        res.saturation_out = sat[CHAN_W-1:0];
        res.value_out      = vmax;
        return res;
    endfunction

    // random pixel, biased toward greys, ties, tiny spreads and full-scale channels
    function automatic t_rgb_in random_pixel();
        t_rgb_in     px;
        int unsigned kind;
        int unsigned hi;
        int unsigned lo;
        int unsigned base;
        kind = $urandom_range(0, 9);
        hi   = $urandom_range(0, 65535);
        lo   = $urandom_range(0, hi);
        base = $urandom_range(0, 65532);
        px.red_in   = 16'($urandom);
        px.green_in = 16'($urandom);
        px.blue_in  = 16'($urandom);
        case (kind)
            5: begin
                px.green_in = px.red_in;
                px.blue_in  = px.red_in;
            end
            6: begin
                case ($urandom_range(0, 2))
                    0: px = '{16'(hi), 16'(hi), 16'(lo)};
                    1: px = '{16'(hi), 16'(lo), 16'(hi)};
                    default: px = '{16'(lo), 16'(hi), 16'(hi)};
                endcase
            end
            7: begin
                px.red_in   = 16'($urandom_range(0, 3));
                px.green_in = 16'($urandom_range(0, 3));
                px.blue_in  = 16'($urandom_range(0, 3));
            end
            8: begin
                case ($urandom_range(0, 2))
                    0: px.red_in = 16'hFFFF;
                    1: px.green_in = 16'hFFFF;
                    default: px.blue_in = 16'hFFFF;
                endcase
            end
            9: begin
                px.red_in   = 16'(base + $urandom_range(0, 3));
                px.green_in = 16'(base + $urandom_range(0, 3));
                px.blue_in  = 16'(base + $urandom_range(0, 3));
            end
            default: begin
            end
        endcase
        return px;
    endfunction

    // offer one pixel after a random gap (none in burst mode) and hold it until the transfer
    task automatic send_pixel(input t_rgb_in px, input logic known, input t_hsv_out hsv);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_pixel   <= px;
        pix_known <= known;
        pix_hsv   <= hsv;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // wait on the falling edge until every expected result has come,
    // first letting the monitor log the transfer of the last edge
    task automatic drain_results();
        @(negedge i_clk);
        while (hsv_expected.size() != 0) @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_pixel    = '0;
        pix_known  = 1'b0;
        pix_hsv    = '0;
        burst_mode = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_pixel(DIRECTED_CASES[i].px, DIRECTED_CASES[i].known, DIRECTED_CASES[i].hsv);
        end

        // random pixels, with back-to-back bursts now and then
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 64 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            if (i == NUM_RANDOM / 2) begin
                start <= 1'b0;
                drain_results();
                @(posedge i_clk);
            end
            send_pixel(random_pixel(), 1'b0, '0);
        end
        start <= 1'b0;

        drain_results();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("rgb_to_hsv_converter test passed");
        end else begin
            $display("rgb_to_hsv_converter test failed");
        end
        $finish;
    end

    // check each result, then log the pixel transferred at this edge
    always @(posedge i_clk) begin
        t_hsv_out want;
        if (i_rst_n) begin
            if (o_done !== 1'b0) begin
                if (hsv_expected.size() == 0) begin
                    if (mismatch_count < MAX_SHOWN) begin
                        $display("unexpected result: hue %h sat %h val %h",
                                 o_hsv.hue_out, o_hsv.saturation_out, o_hsv.value_out);
                    end
                    mismatch_count++;
                end else begin
                    want = hsv_expected.pop_front();
                    if (o_hsv.hue_out !== want.hue_out ||
                        o_hsv.saturation_out !== want.saturation_out ||
                        o_hsv.value_out !== want.value_out) begin
                        if (mismatch_count < MAX_SHOWN) begin
                            $display("mismatch: hue %h/%h sat %h/%h val %h/%h (got/exp)",
                                     o_hsv.hue_out, want.hue_out,
                                     o_hsv.saturation_out, want.saturation_out,
                                     o_hsv.value_out, want.value_out);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy) begin
                hsv_expected.push_back(pix_known ? pix_hsv : hsv_of(i_pixel));
            end
        end
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("rgb_to_hsv_converter test failed");
            $finish;
        end
    end

    initial begin
        mismatch_count = 0;
        cycle_count    = 0;
    end

endmodule
